### hdl/png_pixel_to_mono_overlay_macros.svh
`ifndef PNG_PIXEL_TO_MONO_OVERLAY_MACROS_SVH
`define PNG_PIXEL_TO_MONO_OVERLAY_MACROS_SVH

// same-cycle implication
`define PMO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmo assertion failed");

// next-cycle implication
`define PMO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmo assertion failed");

`endif

### hdl/pmo_pkg.sv
package pmo_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] REG_PIXEL_KIND    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SAMPLE_BITS   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KEY_ENABLE    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KEY_COLOR     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PAL_ALPHA_ON  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PAL_PRESENT   = 3'd5;

  localparam logic [2:0] KIND_GRAY       = 3'd0;
  localparam logic [2:0] KIND_TRUECOLOR  = 3'd1;
  localparam logic [2:0] KIND_INDEXED    = 3'd2;
  localparam logic [2:0] KIND_GRAY_ALPHA = 3'd3;
  localparam logic [2:0] KIND_RGBA       = 3'd4;

  localparam logic ACT_PAL_WRITE = 1'b0;
  localparam logic ACT_PIXEL     = 1'b1;

  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;
  localparam logic [7:0] OPAQUE = 8'd255;

  typedef struct packed {
    logic       action;
    logic [7:0] entry;
    logic [7:0] sample;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
  } pmo_in_t;

  typedef struct packed {
    logic paint;
    logic is_black;
  } pmo_out_t;

  function automatic logic [7:0] sample_mask(input logic [3:0] bits);
    case (bits)
      4'd1: sample_mask = 8'h01;
      4'd2: sample_mask = 8'h03;
      4'd4: sample_mask = 8'h0f;
      default: sample_mask = 8'hff;
    endcase
  endfunction

  function automatic logic [7:0] sample_scale(input logic [3:0] bits);
    case (bits)
      4'd1: sample_scale = 8'd255;
      4'd2: sample_scale = 8'd85;
      4'd4: sample_scale = 8'd17;
      default: sample_scale = 8'd1;
    endcase
  endfunction

endpackage

### hdl/png_pixel_to_mono_overlay.sv
// channel | signals                     | transfer when
// --------+-----------------------------+--------------------------
// in      | in_valid, in_ready, in_data | in_valid && in_ready
// out     | out_valid, out_ready, out_data | out_valid && out_ready
// cfg     | cfg_we, cfg_index, cfg_data | cfg_we
//
// one item per cycle unless the output stalls
// stages: input/palette read, luma products, sum and threshold
// a palette write gives no result
// reset clears valid bits and config registers; palette contents are undefined until written
// each stage holds when the one after it is full and stalled
module png_pixel_to_mono_overlay (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pmo_pkg::pmo_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pmo_pkg::pmo_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [pmo_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [pmo_pkg::CFG_DW-1:0]    cfg_data
);
  import pmo_pkg::*;

  `include "png_pixel_to_mono_overlay_macros.svh"

  logic [2:0]  pixel_kind;
  logic [3:0]  sample_bits;
  logic        key_enable;
  logic [23:0] key_color;
  logic        palette_alpha_on;
  logic        palette_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_kind       <= KIND_GRAY;
      sample_bits      <= 4'd8;
      key_enable       <= 1'b0;
      key_color        <= '0;
      palette_alpha_on <= 1'b0;
      palette_present  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_KIND:   pixel_kind       <= cfg_data[2:0];
        REG_SAMPLE_BITS:  sample_bits      <= cfg_data[3:0];
        REG_KEY_ENABLE:   key_enable       <= cfg_data[0];
        REG_KEY_COLOR:    key_color        <= cfg_data[23:0];
        REG_PAL_ALPHA_ON: palette_alpha_on <= cfg_data[0];
        REG_PAL_PRESENT:  palette_present  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready, o_ready;
  logic in_xfer;

  assign o_ready  = !out_valid || out_ready;
  assign s2_ready = !s2_valid || o_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign in_xfer  = in_valid && in_ready;

  // palette
  logic [31:0] palette [PAL_DEPTH];
  logic [31:0] pal_rd;
  logic [7:0]  in_idx;
  logic        wr_ok;
  logic        idx_ok;

  assign in_idx = in_data.sample & sample_mask(sample_bits);
  assign wr_ok  = {1'b0, in_data.entry} < 9'(PAL_DEPTH);
  assign idx_ok = {1'b0, in_idx} < 9'(PAL_DEPTH);

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.action == ACT_PAL_WRITE && wr_ok) begin
      palette[in_data.entry[PAL_AW-1:0]] <=
        {in_data.red, in_data.green, in_data.blue, in_data.opacity};
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.action == ACT_PIXEL) begin
      pal_rd <= palette[in_idx[PAL_AW-1:0]];
    end
  end

  // stage 1
  logic [7:0] s1_s, s1_sample, s1_r, s1_g, s1_b, s1_a;
  logic       s1_idx_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_xfer && in_data.action == ACT_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.action == ACT_PIXEL) begin
      s1_s      <= in_idx;
      s1_sample <= in_data.sample;
      s1_r      <= in_data.red;
      s1_g      <= in_data.green;
      s1_b      <= in_data.blue;
      s1_a      <= in_data.opacity;
      s1_idx_ok <= idx_ok;
    end
  end

  // stage 2 products
  logic [7:0]  sel_r, sel_g, sel_b;
  logic [7:0]  gray_direct_next, alpha_next;
  logic        use_luma_next, skip_next;
  logic [15:0] scaled;

  assign scaled = {8'd0, s1_s} * {8'd0, sample_scale(sample_bits)};

  always_comb begin
    sel_r            = s1_r;
    sel_g            = s1_g;
    sel_b            = s1_b;
    gray_direct_next = OPAQUE;
    alpha_next       = OPAQUE;
    use_luma_next    = 1'b0;
    skip_next        = 1'b0;
    case (pixel_kind)
      KIND_GRAY: begin
        gray_direct_next = scaled[7:0];
        if (key_enable && s1_s == key_color[7:0]) alpha_next = 8'd0;
      end
      KIND_TRUECOLOR: begin
        use_luma_next = 1'b1;
        if (key_enable && {s1_r, s1_g, s1_b} == key_color) alpha_next = 8'd0;
      end
      KIND_INDEXED: begin
        sel_r         = pal_rd[31:24];
        sel_g         = pal_rd[23:16];
        sel_b         = pal_rd[15:8];
        use_luma_next = 1'b1;
        skip_next     = !palette_present || !s1_idx_ok;
        if (palette_alpha_on) alpha_next = pal_rd[7:0];
      end
      KIND_GRAY_ALPHA: begin
        gray_direct_next = s1_sample;
        alpha_next       = s1_a;
      end
      KIND_RGBA: begin
        use_luma_next = 1'b1;
        alpha_next    = s1_a;
      end
      default: skip_next = 1'b1;
    endcase
  end

  logic [15:0] s2_pr, s2_pg, s2_pb;
  logic [7:0]  s2_gray, s2_alpha;
  logic        s2_use_luma, s2_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_pr       <= {8'd0, sel_r} * {8'd0, LUMA_R};
      s2_pg       <= {8'd0, sel_g} * {8'd0, LUMA_G};
      s2_pb       <= {8'd0, sel_b} * {8'd0, LUMA_B};
      s2_gray     <= gray_direct_next;
      s2_alpha    <= alpha_next;
      s2_use_luma <= use_luma_next;
      s2_skip     <= skip_next;
    end
  end

  // stage 3 sum and threshold
  logic [16:0] luma_sum;
  logic [7:0]  gray;
  logic        paint_next;

  assign luma_sum   = {1'b0, s2_pr} + {1'b0, s2_pg} + {1'b0, s2_pb};
  assign gray       = s2_use_luma ? luma_sum[15:8] : s2_gray;
  assign paint_next = !s2_skip && s2_alpha[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s2_valid) begin
      out_data.paint    <= paint_next;
      out_data.is_black <= paint_next && !gray[7];
    end
  end

  `PMO_ASSERT_NEXT(a_pal_write_no_item,
    in_xfer && in_data.action == ACT_PAL_WRITE && s1_ready, !s1_valid)
  `PMO_ASSERT_NEXT(a_pixel_enters,
    in_xfer && in_data.action == ACT_PIXEL, s1_valid)
  `PMO_ASSERT_NEXT(a_s2_holds, s2_valid && !s2_ready, s2_valid)
  `PMO_ASSERT_NOW(a_black_needs_paint, out_valid && out_data.is_black, out_data.paint)

endmodule
